FILE: hw/rtl/swm_pkg.sv
// Package for the sliding window median filter.
// Holds the sizing constants and the structs shared by the cell chain and the top level.
// No dependencies.
package swm_pkg;

	localparam int MAX_WINDOW = 256;
	localparam int SAMPLE_W   = 32;
	localparam int IDX_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
	localparam int CFG_W      = 9;
	localparam int AGE_W      = IDX_W;

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [AGE_W-1:0]    age_t;

	// What one cell shows its neighbours.
	typedef struct packed {
		sample_t value;
		age_t    age;
		logic    keep;
		logic    evict;
	} cell_bus_t;

	// Broadcast control for every cell of the chain.
	typedef struct packed {
		logic step;
		logic full;
		age_t victim_age;
		logic new_victim;
	} cell_ctrl_t;

endpackage

FILE: hw/rtl/swm_cell.sv
// One cell of the sorted window chain: holds one value and its age.
// Depends on swm_pkg.
module swm_cell (
	input  logic              clk,
	input  logic              held,
	input  swm_pkg::sample_t  sample,
	input  swm_pkg::cell_ctrl_t ctrl,
	input  swm_pkg::cell_bus_t left,
	input  swm_pkg::cell_bus_t right,
	input  logic              shift,
	output swm_pkg::cell_bus_t own,
	output logic              victim
);

	swm_pkg::sample_t value_q;
	swm_pkg::age_t    age_q;
	swm_pkg::sample_t here_value;
	swm_pkg::age_t    here_age;
	swm_pkg::sample_t next_value;
	swm_pkg::age_t    next_age;

	always_comb begin
		own.value = value_q;
		own.age   = age_q;
		own.keep  = held && !(value_q > sample);
		own.evict = held && ctrl.full && (age_q == ctrl.victim_age);

		if (own.keep) begin
			here_value = value_q;
			here_age   = age_q + 1'b1;
		end else if (left.keep) begin
			here_value = sample;
			here_age   = '0;
		end else begin
			here_value = left.value;
			here_age   = left.age + 1'b1;
		end

		if (right.keep) begin
			next_value = right.value;
			next_age   = right.age + 1'b1;
		end else if (own.keep) begin
			next_value = sample;
			next_age   = '0;
		end else begin
			next_value = value_q;
			next_age   = age_q + 1'b1;
		end

		victim = (own.keep && own.evict) ||
			(!own.keep && left.keep && ctrl.new_victim) ||
			(!left.keep && left.evict);
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			if (ctrl.full && shift) begin
				value_q <= next_value;
				age_q   <= next_age;
			end else begin
				value_q <= here_value;
				age_q   <= here_age;
			end
		end
	end

endmodule

FILE: hw/rtl/swm_prefix_or.sv
// Log-depth prefix OR across the cell chain, locating the cells at or after the evicted entry.
// Depends on swm_pkg.
module swm_prefix_or (
	input  logic [swm_pkg::MAX_WINDOW-1:0] hit,
	output logic [swm_pkg::MAX_WINDOW-1:0] at_or_after
);

	logic [swm_pkg::MAX_WINDOW-1:0] lvl [0:swm_pkg::IDX_W];

	assign lvl[0] = hit;

	for (genvar l = 0; l < swm_pkg::IDX_W; l++) begin : g_lvl
		for (genvar i = 0; i < swm_pkg::MAX_WINDOW; i++) begin : g_bit
			if (i >= (1 << l)) begin : g_or
				assign lvl[l+1][i] = lvl[l][i] | lvl[l][i-(1<<l)];
			end else begin : g_pass
				assign lvl[l+1][i] = lvl[l][i];
			end
		end
	end

	assign at_or_after = lvl[swm_pkg::IDX_W];

endmodule

FILE: hw/rtl/swm_obuf.sv
// Two-entry result buffer that decouples the cell chain from the output stall.
// Depends on swm_pkg.
module swm_obuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  swm_pkg::sample_t push_data,
	output logic             out_valid,
	input  logic             out_stall,
	output swm_pkg::sample_t median,
	output logic             full
);

	swm_pkg::sample_t data0_q;
	swm_pkg::sample_t data1_q;
	logic [1:0]       count_q;
	logic             pop;

	assign out_valid = (count_q != 2'd0);
	assign median    = data0_q;
	assign full      = (count_q == 2'd2);
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					data0_q <= push_data;
				end else begin
					data1_q <= push_data;
				end
			end
			2'b01: begin
				data0_q <= data1_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					data0_q <= push_data;
				end else begin
					data0_q <= data1_q;
					data1_q <= push_data;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/sliding_window_median.sv
// Sliding window median filter: a sorted chain of cells with per-entry ages.
// Throughput is one sample per cycle while the result buffer has room; each sample is
// inserted and, once the window is full, the oldest entry evicted in one pass of the chain.
// Reset clears the fill count and sets the window size to three; entry contents are not reset.
// Depends on swm_pkg, swm_cell, swm_prefix_or and swm_obuf.
module sliding_window_median (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [swm_pkg::CFG_W-1:0] window_size,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  swm_pkg::sample_t          sample,
	output logic                      out_valid,
	input  logic                      out_stall,
	output swm_pkg::sample_t          median
);

	localparam swm_pkg::cell_bus_t EDGE_LEFT  = '{value: '0, age: '0, keep: 1'b1, evict: 1'b0};
	localparam swm_pkg::cell_bus_t EDGE_RIGHT = '{value: '0, age: '0, keep: 1'b0, evict: 1'b0};

	logic [swm_pkg::CNT_W-1:0] fill_q;
	logic [swm_pkg::CNT_W-1:0] kmin1_q;
	logic [swm_pkg::IDX_W-1:0] mid_q;
	logic [swm_pkg::IDX_W-1:0] mid_lo_q;
	logic                      mid_zero_q;
	swm_pkg::age_t             victim_age_q;
	logic                      single_q;

	logic [swm_pkg::CNT_W-1:0] k_eff;
	logic                      cfg_wr;
	logic                      accept;
	logic                      full;
	logic                      obuf_full;
	swm_pkg::cell_ctrl_t       ctrl;
	swm_pkg::sample_t          median_d;

	swm_pkg::cell_bus_t             bus [swm_pkg::MAX_WINDOW];
	logic [swm_pkg::MAX_WINDOW-1:0] victim_vec;
	logic [swm_pkg::MAX_WINDOW-1:0] shift_vec;

	assign cfg_ready = !out_valid;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign in_stall  = obuf_full;
	assign accept    = in_valid && !in_stall;
	assign full      = (fill_q == kmin1_q);

	always_comb begin
		if (window_size == '0) begin
			k_eff = swm_pkg::CNT_W'(1);
		end else if (32'(window_size) > 32'(swm_pkg::MAX_WINDOW)) begin
			k_eff = swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW);
		end else begin
			k_eff = swm_pkg::CNT_W'(window_size);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q       <= '0;
			kmin1_q      <= swm_pkg::CNT_W'(2);
			mid_q        <= swm_pkg::IDX_W'(1);
			mid_lo_q     <= '0;
			mid_zero_q   <= 1'b0;
			victim_age_q <= swm_pkg::AGE_W'(1);
			single_q     <= 1'b0;
		end else if (cfg_wr) begin
			fill_q       <= '0;
			kmin1_q      <= k_eff - 1'b1;
			mid_q        <= swm_pkg::IDX_W'((k_eff - 1'b1) >> 1);
			mid_lo_q     <= swm_pkg::IDX_W'(((k_eff - 1'b1) >> 1) - 1'b1);
			mid_zero_q   <= (k_eff < swm_pkg::CNT_W'(3));
			victim_age_q <= swm_pkg::AGE_W'(k_eff - swm_pkg::CNT_W'(2));
			single_q     <= (k_eff == swm_pkg::CNT_W'(1));
		end else if (accept && !full) begin
			fill_q <= fill_q + 1'b1;
		end
	end

	always_comb begin
		ctrl.step       = accept;
		ctrl.full       = full;
		ctrl.victim_age = victim_age_q;
		ctrl.new_victim = single_q && full;
	end

	for (genvar i = 0; i < swm_pkg::MAX_WINDOW; i++) begin : g_cell
		swm_pkg::cell_bus_t left_bus;
		swm_pkg::cell_bus_t right_bus;

		if (i == 0) begin : g_first
			assign left_bus = EDGE_LEFT;
		end else begin : g_mid_l
			assign left_bus = bus[i-1];
		end

		if (i == swm_pkg::MAX_WINDOW - 1) begin : g_last
			assign right_bus = EDGE_RIGHT;
		end else begin : g_mid_r
			assign right_bus = bus[i+1];
		end

		swm_cell u_cell (
			.clk    (clk),
			.held   (swm_pkg::CNT_W'(i) < fill_q),
			.sample (sample),
			.ctrl   (ctrl),
			.left   (left_bus),
			.right  (right_bus),
			.shift  (shift_vec[i]),
			.own    (bus[i]),
			.victim (victim_vec[i])
		);
	end

	swm_prefix_or u_prefix (
		.hit         (victim_vec),
		.at_or_after (shift_vec)
	);

	always_comb begin
		if (bus[mid_q].keep) begin
			median_d = bus[mid_q].value;
		end else if (mid_zero_q || bus[mid_lo_q].keep) begin
			median_d = sample;
		end else begin
			median_d = bus[mid_lo_q].value;
		end
	end

	swm_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && full),
		.push_data (median_d),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.median    (median),
		.full      (obuf_full)
	);

	a_fill_below_window: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= kmin1_q)
		else $error("Fill count has reached the window size.");

	a_single_victim: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> $onehot0(victim_vec))
		else $error("More than one entry marked for eviction.");

	a_victim_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full) |-> $onehot(victim_vec))
		else $error("Full window without exactly one entry to evict.");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && full && !out_valid) |=> out_valid)
		else $error("Accepted request on a full window gave no result.");

endmodule

FILE: tb/sv/sliding_window_median_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the sliding window median filter, with its own
// window predictor, random idling on both sides and a cycle limit. Depends on swm_pkg and sliding_window_median.
module sliding_window_median_test;

	typedef enum int {MIX_FULL, MIX_NARROW, MIX_EXTREME} value_mix_e;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_PAUSE = 4;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_valid   = 1'b0;
	logic                      cfg_ready;
	logic [swm_pkg::CFG_W-1:0] window_size = 9'd3;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	swm_pkg::sample_t          sample      = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	swm_pkg::sample_t          median;

	// Predictor state: the programmed size, the held samples oldest first and the same
	// samples in ascending order.
	logic [swm_pkg::CFG_W-1:0] window_cfg = 9'd3;
	swm_pkg::sample_t          held_samples[$];
	swm_pkg::sample_t          sorted_window[$];
	swm_pkg::sample_t          pending_medians[$];
	swm_pkg::sample_t          expected_median;

	int unsigned error_count   = 0;
	int unsigned sent_count    = 0;
	int unsigned checked_count = 0;
	int unsigned resize_count  = 0;
	int unsigned cycle_count   = 0;
	int unsigned stall_pct     = 25;
	int unsigned hold_cycles   = 0;
	int unsigned gap_max       = 4;
	int unsigned burst_max     = 8;
	int unsigned burst_left    = 0;

	sliding_window_median dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.window_size(window_size),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.median     (median)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[sliding_window_median] ERROR");
			$finish;
		end
	end

	function automatic int unsigned effective_window(input logic [swm_pkg::CFG_W-1:0] raw);
		if (raw == '0)
			return 1;
		if (32'(raw) > 32'(swm_pkg::MAX_WINDOW))
			return swm_pkg::MAX_WINDOW;
		return 32'(raw);
	endfunction

	// A new sample goes after any equal entries; once the window is full the lower median
	// is recorded and the oldest sample leaves.
	function automatic void predict_median(input swm_pkg::sample_t s);
		int unsigned k;
		int unsigned pos;
		swm_pkg::sample_t oldest;
		k = effective_window(window_cfg);
		pos = 0;
		while (pos < sorted_window.size() && sorted_window[pos] <= s)
			pos++;
		sorted_window.insert(pos, s);
		held_samples.insert(held_samples.size(), s);
		if (held_samples.size() < k)
			return;
		pending_medians.insert(pending_medians.size(), sorted_window[(k - 1) / 2]);
		oldest = held_samples.pop_front();
		for (pos = 0; pos < sorted_window.size(); pos++) begin
			if (sorted_window[pos] == oldest) begin
				sorted_window.delete(pos);
				break;
			end
		end
	endfunction

	function automatic swm_pkg::sample_t gen_sample(input value_mix_e mix);
		case (mix)
			MIX_NARROW: return $urandom_range(7);
			MIX_EXTREME: begin
				case ($urandom_range(4))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					3: return 32'h7FFF_FFFF;
					default: return $urandom();
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_medians.size() == 0) begin
				$display("%0t: median expected none, got %h", $time, median);
				error_count++;
			end else begin
				expected_median = pending_medians.pop_front();
				checked_count++;
				if (median !== expected_median) begin
					$display("%0t: median expected %h, got %h", $time, expected_median, median);
					error_count++;
				end
			end
		end
	end

	// Receiver: random runs of taking, each possibly followed by a run of stalling, plus a long hold when a test asks.
	initial begin : receiver
		int unsigned run_left;
		logic stalled;
		run_left = 0;
		stalled = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stalled = !stalled && ($urandom_range(99) < stall_pct);
					run_left = stalled ? $urandom_range(6, 1) : $urandom_range(20, 1);
				end
				run_left--;
				out_stall <= stalled;
			end
		end
	end

	task automatic send_sample(input swm_pkg::sample_t v);
		in_valid <= 1'b1;
		sample <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sent_count++;
		predict_median(v);
	endtask

	task automatic send_with_gaps(input swm_pkg::sample_t v);
		send_sample(v);
		if (burst_left > 0) begin
			burst_left--;
		end else if (gap_max > 0) begin
			in_valid <= 1'b0;
			sample <= $urandom();
			repeat ($urandom_range(gap_max, 1))
				@(posedge clk);
			burst_left = $urandom_range(burst_max, 0);
		end
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (DRAIN_PAUSE)
			@(posedge clk);
	endtask

	task automatic write_window(input logic [swm_pkg::CFG_W-1:0] k);
		wait_drained();
		cfg_valid <= 1'b1;
		window_size <= k;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		window_cfg = k;
		held_samples.delete();
		sorted_window.delete();
		resize_count++;
	endtask

	task automatic test_default_window();
		send_with_gaps(32'h0000_0000);
		send_with_gaps(32'hFFFF_FFFF);
		send_with_gaps(32'h0000_0007);
		send_with_gaps(32'h0000_0007);
		send_with_gaps(32'h0000_0007);
		send_with_gaps(32'h0000_0000);
		send_with_gaps(32'hFFFF_FFFF);
		send_with_gaps(32'h0000_0001);
	endtask

	task automatic test_pass_through();
		write_window(9'd1);
		send_with_gaps(32'hFFFF_FFFF);
		send_with_gaps(32'h0000_0000);
		send_with_gaps(32'h8000_0000);
		send_with_gaps(32'h0000_0001);
	endtask

	task automatic test_zero_window();
		write_window(9'd0);
		send_with_gaps(32'h1234_5678);
		send_with_gaps(32'hFFFF_FFFF);
		send_with_gaps(32'h0000_0000);
	endtask

	task automatic test_equal_samples();
		write_window(9'd4);
		send_with_gaps(32'd5);
		send_with_gaps(32'd5);
		send_with_gaps(32'd5);
		send_with_gaps(32'd5);
		send_with_gaps(32'd2);
		send_with_gaps(32'd9);
	endtask

	task automatic test_resize_mid_stream();
		write_window(9'd5);
		send_with_gaps(32'd100);
		send_with_gaps(32'd3);
		send_with_gaps(32'd50);
		write_window(9'd2);
		send_with_gaps(32'd7);
		send_with_gaps(32'd1);
		send_with_gaps(32'd9);
	endtask

	task automatic test_largest_window();
		write_window(swm_pkg::CFG_W'(swm_pkg::MAX_WINDOW));
		gap_max = 3;
		burst_max = 30;
		stall_pct = 20;
		repeat (swm_pkg::MAX_WINDOW + 20)
			send_with_gaps(gen_sample(value_mix_e'($urandom_range(2))));
	endtask

	task automatic test_saturated_window();
		write_window(9'h1FF);
		repeat (swm_pkg::MAX_WINDOW + 10)
			send_with_gaps($urandom());
	endtask

	task automatic test_backpressure();
		write_window(9'd4);
		gap_max = 0;
		stall_pct = 0;
		hold_cycles = 300;
		repeat (40)
			send_with_gaps($urandom());
		// The sender stops here until every median has been taken.
		wait_drained();
		stall_pct = 30;
		repeat (20)
			send_with_gaps($urandom_range(15));
	endtask

	task automatic test_random_stream();
		int unsigned left;
		int unsigned len;
		logic [swm_pkg::CFG_W-1:0] k;
		value_mix_e mix;
		left = 720;
		while (left > 0) begin
			case ($urandom_range(19))
				0:       k = 9'd0;
				1, 2, 3: k = swm_pkg::CFG_W'($urandom_range(40, 9));
				default: k = swm_pkg::CFG_W'($urandom_range(8, 1));
			endcase
			write_window(k);
			case ($urandom_range(3))
				0:       stall_pct = 0;
				1:       stall_pct = 10;
				2:       stall_pct = 35;
				default: stall_pct = 65;
			endcase
			gap_max = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
			burst_max = $urandom_range(16);
			burst_left = 0;
			mix = value_mix_e'($urandom_range(2));
			len = $urandom_range(80, 20);
			if (len > left)
				len = left;
			repeat (len)
				send_with_gaps(gen_sample(mix));
			left -= len;
		end
	endtask

	initial begin
		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_window();
		test_pass_through();
		test_zero_window();
		test_equal_samples();
		test_resize_mid_stream();
		test_largest_window();
		test_saturated_window();
		test_backpressure();
		test_random_stream();
		wait_drained();
		repeat (8)
			@(posedge clk);
		$display("Sent %0d samples and checked %0d medians over %0d window size changes.",
			sent_count, checked_count, resize_count);
		$display("Window sizes from zero to the saturated maximum, with stalls on both sides.");
		if (error_count == 0)
			$display("[sliding_window_median] OK");
		else
			$display("[sliding_window_median] ERROR");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/swm_pkg.sv
hw/rtl/swm_cell.sv
hw/rtl/swm_prefix_or.sv
hw/rtl/swm_obuf.sv
hw/rtl/sliding_window_median.sv
tb/sv/sliding_window_median_test.sv
